// ----- src/els_pkg.sv -----
`default_nettype none

package els_pkg;

   // Flight mode, held one-hot inside the block.
   typedef enum logic [3:0] {
      MODE_DISARMED = 4'b0001,
      MODE_ARMED    = 4'b0010,
      MODE_LANDING  = 4'b0100,
      MODE_STOPPED  = 4'b1000
   } mode_type;

   // Flight mode codes as they appear on the result channel.
   localparam logic [1:0] FM_DISARMED = 2'd0;
   localparam logic [1:0] FM_ARMED    = 2'd1;
   localparam logic [1:0] FM_LANDING  = 2'd2;
   localparam logic [1:0] FM_STOPPED  = 2'd3;

   // Event codes reported with each result item.
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_BUTTON    = 3'd1,
      EV_LINK_LOST = 3'd2,
      EV_GROUND    = 3'd3,
      EV_RECOVERED = 3'd4
   } evt_code_type;

   // Configuration register indexes (byte address is four times the index).
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_LINK_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_CUTOFF_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DESCENT_STEP  = 2'd2;
   localparam logic [1:0] REG_DESCENT_PERIOD = 2'd3;

   localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd1000;
   localparam logic [15:0] RST_CUTOFF_HEIGHT  = 16'd100;
   localparam logic [15:0] RST_DESCENT_STEP   = 16'd25;
   localparam logic [15:0] RST_DESCENT_PERIOD = 16'd50;

   typedef struct packed {
      logic        button_pressed;
      logic        link_up;
      logic        lidar_enabled;
      logic [15:0] lidar_height_mm;
      logic [15:0] current_height_mm;
      logic        arm_request;
      logic        disarm_request;
   } req_type;

   typedef struct packed {
      logic [1:0]  flight_mode;
      logic        target_valid;
      logic [15:0] target_height_mm;
      logic [2:0]  event_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] link_timeout_ms;
      logic [15:0] cutoff_height_mm;
      logic [15:0] descent_step_mm;
      logic [15:0] descent_period_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        button_prev;
      logic [15:0] link_lost_ms;
      logic        landing_started;
      logic [15:0] descent_target_mm;
      logic [15:0] descent_elapsed_ms;
   } state_type;

   // Encode the one-hot mode into the result code.
   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] code;
      case (m)
         MODE_DISARMED: code = FM_DISARMED;
         MODE_ARMED:    code = FM_ARMED;
         MODE_LANDING:  code = FM_LANDING;
         MODE_STOPPED:  code = FM_STOPPED;
         default:       code = FM_DISARMED;
      endcase
      return code;
   endfunction

   // Counter that sticks at its largest value.
   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

// ----- src/emergency_landing_supervisor.sv -----
`default_nettype none

// Emergency landing supervisor. Each req item is one millisecond tick and
// produces exactly one rsp item, in order. An accepted item is held in an
// input register until the result side is free, then the supervisor state
// and the result register are updated together, so rsp_valid rises once the
// item has moved from the input register into the result register. The block
// takes one item every cycle while rsp_ready is high; a result held by a low
// rsp_ready stalls req_ready only once the input register is also full. The
// supervisor state is a single register set updated once per item, which is
// what fixes the rate at one item per cycle.
// Configuration registers sit on the APB-style csr port at byte addresses 0,
// 4, 8 and 12; write them only while no item is in flight.
module emergency_landing_supervisor
   import els_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req_payload,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready
);

   cfg_type   cfg;
   logic      in_v_ff;
   logic      in_v_in;
   req_type   in_data_ff;
   logic      out_v_ff;
   logic      out_v_in;
   rsp_type   out_data_ff;
   state_type state_ff;
   state_type state_nxt;
   rsp_type   rsp_nxt;
   logic      out_free;
   logic      advance;
   logic      req_take;

   els_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   els_step u_step (
      .item (in_data_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_nxt),
      .rsp  (rsp_nxt)
   );

   // Pipeline flow control.
   assign out_free  = !out_v_ff || rsp_ready;
   assign advance   = in_v_ff && out_free;
   assign req_ready = !in_v_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_v_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_v_ff);
   assign out_v_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

   // Valid flags and supervisor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff                     <= 1'b0;
         out_v_ff                    <= 1'b0;
         state_ff.mode               <= MODE_DISARMED;
         state_ff.button_prev        <= 1'b0;
         state_ff.link_lost_ms       <= 16'd0;
         state_ff.landing_started    <= 1'b0;
         state_ff.descent_target_mm  <= 16'd0;
         state_ff.descent_elapsed_ms <= 16'd0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= rsp_nxt;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_data_ff;

   // A processed item always shows up on the result side next cycle.
   a_adv_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item did not reach the result register");

   // An item waiting in the input register is not dropped while blocked.
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && !out_free) |=> in_v_ff)
      else $error("blocked input item was lost");

   // A ground event always leaves the block stopped with no target update.
   a_ground: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.event_code == EV_GROUND) |->
      (rsp_payload.flight_mode == FM_STOPPED && !rsp_payload.target_valid))
      else $error("ground event with wrong mode or target update");

   // Link recovery always returns to armed.
   a_recover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.event_code == EV_RECOVERED) |->
      rsp_payload.flight_mode == FM_ARMED)
      else $error("link recovery without armed mode");

   // A target update is reported only in landing or armed mode (armed when link recovery ends the landing).
   a_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.target_valid) |->
      (rsp_payload.flight_mode == FM_LANDING || rsp_payload.flight_mode == FM_ARMED))
      else $error("target update outside a landing");

endmodule

`default_nettype wire

// ----- src/els_csr.sv -----
`default_nettype none

module els_csr
   import els_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output      logic [31:0]           csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Register write decode; only the low 16 bits of the data are kept.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LINK_TIMEOUT:   cfg_in.link_timeout_ms   = csr_pwdata[15:0];
            REG_CUTOFF_HEIGHT:  cfg_in.cutoff_height_mm  = csr_pwdata[15:0];
            REG_DESCENT_STEP:   cfg_in.descent_step_mm   = csr_pwdata[15:0];
            REG_DESCENT_PERIOD: cfg_in.descent_period_ms = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout_ms   <= RST_LINK_TIMEOUT;
         cfg_ff.cutoff_height_mm  <= RST_CUTOFF_HEIGHT;
         cfg_ff.descent_step_mm   <= RST_DESCENT_STEP;
         cfg_ff.descent_period_ms <= RST_DESCENT_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (reg_idx)
         REG_LINK_TIMEOUT:   csr_prdata = {16'd0, cfg_ff.link_timeout_ms};
         REG_CUTOFF_HEIGHT:  csr_prdata = {16'd0, cfg_ff.cutoff_height_mm};
         REG_DESCENT_STEP:   csr_prdata = {16'd0, cfg_ff.descent_step_mm};
         REG_DESCENT_PERIOD: csr_prdata = {16'd0, cfg_ff.descent_period_ms};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/els_step.sv -----
`default_nettype none

module els_step
   import els_pkg::*;
(
   input  wire req_type   item,
   input  wire state_type cur,
   input  wire cfg_type   cfg,
   output      state_type nxt,
   output      rsp_type   rsp
);

   // One tick of the supervisor: mode requests, button edge, link timeout,
   // then the landing step. A later stage's event overrides an earlier one.
   always_comb begin
      state_type    s;
      evt_code_type ev;
      logic         valid;
      logic         grounded;

      s        = cur;
      ev       = EV_NONE;
      valid    = 1'b0;
      grounded = 1'b0;

      // Time passes for both counters.
      s.link_lost_ms       = sat_inc16(cur.link_lost_ms);
      s.descent_elapsed_ms = sat_inc16(cur.descent_elapsed_ms);

      // External requests; disarm has priority.
      if (item.disarm_request) begin
         s.mode = MODE_DISARMED;
      end else if (item.arm_request) begin
         s.mode = MODE_ARMED;
      end

      // Button rising edge while armed starts a landing.
      if (item.button_pressed && !cur.button_prev && s.mode == MODE_ARMED) begin
         s.mode = MODE_LANDING;
         ev     = EV_BUTTON;
      end
      s.button_prev = item.button_pressed;

      // Link-loss timeout while armed.
      if (s.mode == MODE_ARMED) begin
         if (item.link_up) begin
            s.link_lost_ms = 16'd0;
         end else if (s.link_lost_ms > cfg.link_timeout_ms) begin
            s.mode = MODE_LANDING;
            ev     = EV_LINK_LOST;
         end
      end

      // Landing step.
      if (s.mode == MODE_LANDING) begin
         if (!s.landing_started) begin
            s.descent_target_mm  = item.current_height_mm;
            s.landing_started    = 1'b1;
            s.descent_elapsed_ms = 16'd0;
         end
         if (s.descent_elapsed_ms > cfg.descent_period_ms) begin
            s.descent_elapsed_ms = 16'd0;
            if (item.lidar_enabled && item.lidar_height_mm < cfg.cutoff_height_mm) begin
               s.mode            = MODE_STOPPED;
               s.landing_started = 1'b0;
               ev                = EV_GROUND;
               grounded          = 1'b1;
            end else begin
               s.descent_target_mm = (s.descent_target_mm > cfg.descent_step_mm) ?
                                     s.descent_target_mm - cfg.descent_step_mm : 16'd0;
               valid = 1'b1;
            end
         end
         if (!grounded && item.link_up) begin
            s.mode            = MODE_ARMED;
            s.landing_started = 1'b0;
            ev                = EV_RECOVERED;
         end
      end

      nxt                  = s;
      rsp.flight_mode      = mode_code(s.mode);
      rsp.target_valid     = valid;
      rsp.target_height_mm = s.descent_target_mm;
      rsp.event_code       = ev;
   end

endmodule

`default_nettype wire
